>>> rtl/h263rtp_pkg.sv
// Shared types and constants of the H.263 RTP packetizer.
`timescale 1ns / 1ps
package h263rtp_pkg;

  localparam int RUN_MAX = 5;

  localparam logic [7:0] HDR_PBIT = 8'h04;
  localparam logic [7:0] HDR_ZERO = 8'h00;
  localparam logic [7:0] PIC_MIN  = 8'h80;

  localparam logic [13:0] MTU_MIN   = 14'd16;
  localparam logic [13:0] MTU_RESET = 14'd1400;

  // Progress through the held lead bytes of a frame.
  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_ONE  = 2'd1,
    LEAD_TWO  = 2'd2,
    LEAD_DONE = 2'd3
  } h263rtp_lead_t;

  // The output bytes caused by one input byte, with their packet ends.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] data;
    logic [RUN_MAX-1:0]      pend;
    logic [2:0]              len;
    logic                    last;
  } h263rtp_run_t;

  typedef struct packed {
    logic         valid;
    h263rtp_run_t run;
  } h263rtp_push_t;

endpackage

>>> rtl/h263rtp_in_if.sv
// Input byte channel of the packetizer.
`timescale 1ns / 1ps
interface h263rtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;

  modport source (output valid, output in_byte, output frame_last, input ready);
  modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

>>> rtl/h263rtp_out_if.sv
// Output packet byte channel of the packetizer.
`timescale 1ns / 1ps
interface h263rtp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       frame_marker;
  logic       run_last;

  modport source (output valid, output out_byte, output packet_end, output frame_marker,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input packet_end, input frame_marker,
                  input run_last, output ready);
endinterface

>>> rtl/h263rtp_cfg.sv
// APB register file holding the packet size limit.
`timescale 1ns / 1ps
module h263rtp_cfg
  import h263rtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [13:0] mtu
);

  logic wr_en;

  // Only one register exists, so every address in the window selects it.
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00);
  assign pready = 1'b1;
  assign prdata = {18'd0, mtu};

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu <= MTU_RESET;
    end else if (wr_en) begin
      mtu <= pwdata[13:0];
    end
  end

endmodule

>>> rtl/h263rtp_lead.sv
// Frame front end: lead byte hold, header choice and packet cutting per input byte.
`timescale 1ns / 1ps
module h263rtp_lead
  import h263rtp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          frame_last,
  input  logic [13:0]   mtu,
  output h263rtp_push_t push
);

  h263rtp_lead_t lead;
  h263rtp_lead_t lead_next;
  logic [7:0]    held [2];
  logic [13:0]   fill;
  logic [13:0]   fill_next;
  logic [13:0]   lim;
  logic [7:0]    head0;
  h263rtp_run_t  run;

  assign lim   = (mtu < MTU_MIN) ? MTU_MIN : mtu;
  assign head0 = (lead == LEAD_NONE) ? in_byte : held[0];

  // Next lead state.
  always_comb begin
    if (frame_last) begin
      lead_next = LEAD_NONE;
    end else begin
      case (lead)
        LEAD_NONE: lead_next = LEAD_ONE;
        LEAD_ONE:  lead_next = LEAD_TWO;
        LEAD_TWO:  lead_next = LEAD_DONE;
        LEAD_DONE: lead_next = LEAD_DONE;
        default:   lead_next = LEAD_NONE;
      endcase
    end
  end

  // Bytes of the run caused by this input.
  always_comb begin
    run      = '0;
    run.last = frame_last;
    case (lead)
      LEAD_NONE, LEAD_ONE: begin
        if (frame_last) begin
          // A short frame goes out behind a plain zero header.
          run.data[0] = HDR_ZERO;
          run.data[1] = HDR_ZERO;
          run.data[2] = head0;
          run.data[3] = in_byte;
          run.len     = (lead == LEAD_ONE) ? 3'd4 : 3'd3;
        end
      end
      LEAD_TWO: begin
        if (held[0] == HDR_ZERO && held[1] == HDR_ZERO && in_byte >= PIC_MIN) begin
          // Picture start code: the two zero bytes become the P-bit header.
          run.data[0] = HDR_PBIT;
          run.data[1] = HDR_ZERO;
          run.data[2] = in_byte;
          run.len     = 3'd3;
        end else begin
          run.data[0] = HDR_ZERO;
          run.data[1] = HDR_ZERO;
          run.data[2] = held[0];
          run.data[3] = held[1];
          run.data[4] = in_byte;
          run.len     = 3'd5;
        end
      end
      LEAD_DONE: begin
        if (fill == 14'd0) begin
          run.data[0] = HDR_ZERO;
          run.data[1] = HDR_ZERO;
          run.data[2] = in_byte;
          run.len     = 3'd3;
        end else begin
          run.data[0] = in_byte;
          run.len     = 3'd1;
        end
      end
      default: begin
        run.len = 3'd0;
      end
    endcase
  end

  // Packet fill walks the run; at most five short steps.
  always_comb begin
    logic [13:0]        f;
    logic [RUN_MAX-1:0] pend;
    f    = fill;
    pend = '0;
    for (int i = 0; i < RUN_MAX; i++) begin
      if (3'(i) < run.len) begin
        f       = f + 14'd1;
        pend[i] = (f >= lim) || ((3'(i) == run.len - 3'd1) && frame_last);
        if (pend[i]) begin
          f = 14'd0;
        end
      end
    end
    fill_next = frame_last ? 14'd0 : f;
    push.valid = accept && (run.len != 3'd0);
    push.run   = run;
    push.run.pend = pend;
  end

  always_ff @(posedge clk) begin
    if (accept && (lead == LEAD_NONE || lead == LEAD_ONE)) begin
      held[lead[0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= LEAD_NONE;
      fill <= 14'd0;
    end else if (accept) begin
      lead <= lead_next;
      fill <= fill_next;
    end
  end

endmodule

>>> rtl/h263rtp_runq.sv
// Two-entry run queue that sends the queued bytes out one per cycle while out_ch is ready.
`timescale 1ns / 1ps
module h263rtp_runq
  import h263rtp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  h263rtp_push_t        push,
  output logic                 can_accept,
  h263rtp_out_if.source        out_ch
);

  h263rtp_run_t q [2];
  h263rtp_run_t head;
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [2:0]   idx;
  logic         at_end;
  logic         fire;
  logic         pop;

  assign head       = q[rd_ptr];
  assign at_end     = (idx == head.len - 3'd1);
  assign fire       = out_ch.valid && out_ch.ready;
  assign pop        = fire && at_end;
  assign can_accept = (count != 2'd2);

  assign out_ch.valid        = (count != 2'd0);
  assign out_ch.out_byte     = head.data[idx];
  assign out_ch.packet_end   = head.pend[idx];
  assign out_ch.run_last     = at_end;
  assign out_ch.frame_marker = at_end && head.last;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q[wr_ptr] <= push.run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      idx    <= 3'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (fire) begin
        if (at_end) begin
          idx    <= 3'd0;
          rd_ptr <= ~rd_ptr;
        end else begin
          idx <= idx + 3'd1;
        end
      end
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/h263_rtp_packetizer_top.sv
// Top level of the H.263 RTP packetizer.
//
//   channel  | direction | request contents
//   ---------+-----------+------------------------------------------------------
//   in_ch    | in        | in_byte, frame_last
//   out_ch   | out       | out_byte, packet_end, frame_marker, run_last
//   APB      | in        | mtu at every address (14 bits, write and read)
//
// An input request is taken in the cycle it is offered whenever fewer than two
// runs wait in the run queue; its output run (zero to five bytes) is decided in
// that same cycle and leaves one byte per cycle from the queue head while out_ch
// is ready. Data bytes give one output byte each, so with out_ch ready the block
// sustains one request per cycle; headers and held lead bytes add output cycles.
// Reset is synchronous and clears the lead state, the packet fill and the queue,
// and sets mtu to 1400. A stall on the output fills the two-run queue before
// the input side sees ready drop; no ready path runs straight through.
`timescale 1ns / 1ps
module h263_rtp_packetizer_top
  import h263rtp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  h263rtp_in_if.sink    in_ch,
  h263rtp_out_if.source out_ch
);

  logic          can_accept;
  logic          accept;
  logic [13:0]   mtu;
  h263rtp_push_t push;

  assign in_ch.ready = can_accept;
  assign accept      = in_ch.valid && can_accept;

  h263rtp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mtu     (mtu)
  );

  // The front end decides each request's header and packet ends combinationally, in the cycle it is taken.
  h263rtp_lead u_lead (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_ch.in_byte),
    .frame_last (in_ch.frame_last),
    .mtu        (mtu),
    .push       (push)
  );

  // The queue holds finished runs and hands them to the output byte by byte.
  h263rtp_runq u_runq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .can_accept (can_accept),
    .out_ch     (out_ch)
  );

endmodule

>>> rtl/h263rtp_chk.sv
// Port checker for the packetizer and its bind to the top level.
`timescale 1ns / 1ps
module h263rtp_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       packet_end,
  input logic       frame_marker,
  input logic       run_last
);

  // A stalled output request keeps its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output byte changed under stall");

  // The frame marker closes both the packet and the run.
  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_marker |-> packet_end && run_last)
    else $error("frame marker without packet or run end");

  // Bytes of one run follow without a gap.
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("run broken off before its last byte");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind h263_rtp_packetizer_top h263rtp_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .packet_end   (out_ch.packet_end),
  .frame_marker (out_ch.frame_marker),
  .run_last     (out_ch.run_last)
);
